// File: sv/pfd_pkg.sv
// Shared types, constants and header lookup for the provisioning frame deframer.
package pfd_pkg;

    localparam int unsigned HdrLen     = 6;
    localparam int unsigned TypeOffset = 7;
    localparam int unsigned LenOffset  = 8;
    localparam int unsigned CmdOffset  = 9;
    localparam int unsigned FrameExtra = 10;

    localparam logic [7:0] TypeRpc = 8'h03;
    localparam logic [7:0] CmdMin  = 8'h01;
    localparam logic [7:0] CmdMax  = 8'h04;

    typedef enum logic [1:0] {
        KIND_CONSOLE = 2'd0,
        KIND_FRAME   = 2'd1,
        KIND_VERDICT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        VERD_BAD_SUM  = 2'd0,
        VERD_NOT_RPC  = 2'd1,
        VERD_KNOWN    = 2'd2,
        VERD_UNKNOWN  = 2'd3
    } t_verdict;

    // One burst of results caused by a single accepted byte.
    typedef struct packed {
        logic       is_frame;   // frame byte (plus optional verdict) vs console flush
        logic [2:0] hcnt;       // held header bytes to flush
        logic [2:0] cnt;        // total results in the burst, 1 to 6
        logic [7:0] byte_val;   // received byte
        logic [8:0] offset;     // frame offset of the byte
        t_verdict   verdict;
        logic [7:0] command;
    } t_desc;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h49; // 'I'
            3'd1:    c = 8'h4D; // 'M'
            3'd2:    c = 8'h50; // 'P'
            3'd3:    c = 8'h52; // 'R'
            3'd4:    c = 8'h4F; // 'O'
            3'd5:    c = 8'h56; // 'V'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: sv/pfd_emitter.sv
// Burst emitter: skid slot plus active burst register, one result per transfer.
module pfd_emitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_desc_valid,
    input  pfd_pkg::t_desc    i_desc,
    output logic              o_desc_ready,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [31:0]       o_tdata,   // byte_value[7:0], frame_offset[16:8],
                                         // verdict[18:17], command[26:19], zero pad
    output logic [1:0]        o_tuser,   // kind[1:0]
    output logic              o_tlast
);

    logic           r_d_valid, n_d_valid;
    pfd_pkg::t_desc r_d, n_d;
    logic [2:0]     r_idx, n_idx;
    logic           r_k_valid, n_k_valid;
    pfd_pkg::t_desc r_k, n_k;

    logic d_last, d_adv, d_free, accept;

    assign o_desc_ready = !r_k_valid;
    assign accept       = i_desc_valid && !r_k_valid;
    assign d_last       = (r_idx == (r_d.cnt - 3'd1));
    assign d_adv        = r_d_valid && i_tready;
    assign d_free       = !r_d_valid || (d_adv && d_last);

    always_comb begin
        n_d_valid = r_d_valid;
        n_d       = r_d;
        n_idx     = r_idx;
        n_k_valid = r_k_valid;
        n_k       = r_k;
        if (d_free) begin
            n_idx = 3'd0;
            if (r_k_valid) begin
                n_d_valid = 1'b1;
                n_d       = r_k;
                n_k_valid = 1'b0;
            end else if (accept) begin
                n_d_valid = 1'b1;
                n_d       = i_desc;
            end else begin
                n_d_valid = 1'b0;
            end
        end else begin
            if (d_adv) begin
                n_idx = r_idx + 3'd1;
            end
            if (accept) begin
                n_k_valid = 1'b1;
                n_k       = i_desc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_k_valid <= 1'b0;
            r_idx     <= 3'd0;
        end else begin
            r_d_valid <= n_d_valid;
            r_k_valid <= n_k_valid;
            r_idx     <= n_idx;
        end
        r_d <= n_d;
        r_k <= n_k;
    end

    // Decode the current result of the active burst.
    logic [7:0] f_byte;
    logic [8:0] f_off;
    logic [1:0] f_verd;
    logic [7:0] f_cmd;
    logic [1:0] f_kind;

    always_comb begin
        f_byte = 8'd0;
        f_off  = 9'd0;
        f_verd = 2'd0;
        f_cmd  = 8'd0;
        f_kind = pfd_pkg::KIND_CONSOLE;
        if (r_d.is_frame) begin
            if (r_idx == 3'd0) begin
                f_kind = pfd_pkg::KIND_FRAME;
                f_byte = r_d.byte_val;
                f_off  = r_d.offset;
            end else begin
                f_kind = pfd_pkg::KIND_VERDICT;
                f_verd = r_d.verdict;
                f_cmd  = r_d.command;
            end
        end else if (r_idx < r_d.hcnt) begin
            f_byte = pfd_pkg::hdr_char(r_idx);
        end else begin
            f_byte = r_d.byte_val;
        end
    end

    assign o_tvalid = r_d_valid;
    assign o_tdata  = {5'd0, f_cmd, f_verd, f_off, f_byte};
    assign o_tuser  = f_kind;
    assign o_tlast  = d_last;

endmodule

// File: sv/provisioning_frame_deframer_unit.sv
// Top level of the provisioning frame deframer: header match, frame tracking, verdicts.
// The first result of an accepted byte is offered in the cycle after its transfer
//   when no earlier burst is still pending.
// Throughput with m_tready high: one byte per cycle while each byte yields one result;
//   a broken header emits up to six results, one per cycle, a closing frame byte two.
// A one-entry skid slot keeps s_tready registered and takes a byte while output stalls.
// Reset (synchronous, active low) clears frame position, sum, header fields and buffers.
module provisioning_frame_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // byte_value[7:0], frame_offset[16:8],
                                    // verdict[18:17], command[26:19], zero pad
    output logic [1:0]  m_tuser,    // kind[1:0]
    output logic        m_tlast
);

    // Frame tracking state.
    logic [8:0] r_pos, n_pos;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_len, n_len;
    logic [7:0] r_type, n_type;
    logic [7:0] r_cmd, n_cmd;

    logic           accept;
    logic           desc_ready;
    pfd_pkg::t_desc desc;
    logic           closes;
    logic [7:0]     b;

    assign b        = s_tdata;
    assign s_tready = desc_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        n_pos  = r_pos;
        n_sum  = r_sum;
        n_len  = r_len;
        n_type = r_type;
        n_cmd  = r_cmd;
        closes = 1'b0;
        desc          = '0;
        desc.byte_val = b;
        desc.verdict  = pfd_pkg::VERD_BAD_SUM;

        if (r_pos < 9'(pfd_pkg::HdrLen)) begin
            if (b == pfd_pkg::hdr_char(r_pos[2:0])) begin
                // Hold the matched header byte; no result.
                n_sum = ((r_pos == 9'd0) ? 8'd0 : r_sum) + b;
                n_pos = r_pos + 9'd1;
            end else begin
                // Flush held header bytes; restart on 'I', else forward the byte.
                desc.hcnt = r_pos[2:0];
                if (b == pfd_pkg::hdr_char(3'd0)) begin
                    desc.cnt = r_pos[2:0];
                    n_pos    = 9'd1;
                    n_sum    = b;
                end else begin
                    desc.cnt = r_pos[2:0] + 3'd1;
                    n_pos    = 9'd0;
                    n_sum    = 8'd0;
                end
            end
        end else begin
            desc.is_frame = 1'b1;
            desc.offset   = r_pos;
            desc.cnt      = 3'd1;
            if (r_pos == 9'(pfd_pkg::TypeOffset)) n_type = b;
            if (r_pos == 9'(pfd_pkg::LenOffset))  n_len  = b;
            if (r_pos == 9'(pfd_pkg::CmdOffset))  n_cmd  = b;

            closes = (r_pos >= 9'(pfd_pkg::CmdOffset)) &&
                     (r_pos == (9'(pfd_pkg::FrameExtra - 1) + {1'b0, r_len}));
            if (closes) begin
                // Checksum byte: append the verdict and return to header hunt.
                desc.cnt     = 3'd2;
                desc.command = n_cmd;
                if (r_sum != b)
                    desc.verdict = pfd_pkg::VERD_BAD_SUM;
                else if (r_type != pfd_pkg::TypeRpc)
                    desc.verdict = pfd_pkg::VERD_NOT_RPC;
                else if ((n_cmd >= pfd_pkg::CmdMin) && (n_cmd <= pfd_pkg::CmdMax))
                    desc.verdict = pfd_pkg::VERD_KNOWN;
                else
                    desc.verdict = pfd_pkg::VERD_UNKNOWN;
                n_pos = 9'd0;
                n_sum = 8'd0;
            end else begin
                n_sum = r_sum + b;
                n_pos = r_pos + 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 9'd0;
            r_sum  <= 8'd0;
            r_len  <= 8'd0;
            r_type <= 8'd0;
            r_cmd  <= 8'd0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_len  <= n_len;
            r_type <= n_type;
            r_cmd  <= n_cmd;
        end
    end

    // Bytes that only extend the header produce no burst and skip the emitter.
    pfd_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (accept && (desc.cnt != 3'd0)),
        .i_desc       (desc),
        .o_desc_ready (desc_ready),
        .o_tvalid     (m_tvalid),
        .i_tready     (m_tready),
        .o_tdata      (m_tdata),
        .o_tuser      (m_tuser),
        .o_tlast      (m_tlast)
    );

    // Position never runs past the longest frame.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= 9'd264)
        else $error("frame position out of range");

    // A verdict is always the final result of its byte.
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser == pfd_pkg::KIND_VERDICT)) |-> m_tlast)
        else $error("verdict without tlast");

    // Closing a frame returns the parser to header hunt.
    a_close_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && closes) |=> (r_pos == 9'd0) && (r_sum == 8'd0))
        else $error("frame close did not clear position");

endmodule
